// ===== hw/rtl/wsd_pkg.sv =====
// Shared types and codes for the WebSocket frame deframer.
package wsd_pkg;

  // Input beat: one received frame byte and the end-of-chunk flag
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } wsd_in_t;

  // Result beat
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [3:0] frame_opcode;
    logic [3:0] status;
    logic       frame_end;
  } wsd_out_t;

  // Parse phases
  localparam logic [3:0] PH_HDR0 = 4'd0;
  localparam logic [3:0] PH_HDR1 = 4'd1;
  localparam logic [3:0] PH_EXT0 = 4'd2;
  localparam logic [3:0] PH_EXT1 = 4'd3;
  localparam logic [3:0] PH_KEY0 = 4'd4;
  localparam logic [3:0] PH_KEY1 = 4'd5;
  localparam logic [3:0] PH_KEY2 = 4'd6;
  localparam logic [3:0] PH_KEY3 = 4'd7;
  localparam logic [3:0] PH_DATA = 4'd8;

  // Status codes
  localparam logic [3:0] ST_RUN      = 4'd0;
  localparam logic [3:0] ST_TEXT     = 4'd1;
  localparam logic [3:0] ST_SHORT    = 4'd2;
  localparam logic [3:0] ST_EXTMISS  = 4'd3;
  localparam logic [3:0] ST_LEN64    = 4'd4;
  localparam logic [3:0] ST_UNMASKED = 4'd5;
  localparam logic [3:0] ST_TRUNC    = 4'd6;
  localparam logic [3:0] ST_CLOSE    = 4'd7;
  localparam logic [3:0] ST_NONTEXT  = 4'd8;

  // Opcodes and header fields
  localparam logic [3:0] OPC_TEXT   = 4'h1;
  localparam logic [3:0] OPC_CLOSE  = 4'h8;
  localparam logic [6:0] LEN_EXT16  = 7'd126;
  localparam logic [6:0] LEN_EXT64  = 7'd127;

endpackage

// ===== hw/rtl/websocket_frame_deframer_core.sv =====
// Top level of the WebSocket frame deframer: input register, parser, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in_     | in        | in_valid / in_ready  | in_beat  (byte_value, last_byte)
//  out_    | out       | out_valid / out_ready| out_beat (payload_byte, payload_valid,
//          |           |                      |           frame_opcode, status, frame_end)
//
// One byte per cycle sustained while out_ready does not stall; a taken byte is held in the
// input register, and its result is then loaded into the result register that drives out_valid.
// The parser state advances when the byte in the input register moves on; a byte
// that makes no result moves on even while the result register is full.
// Stalls on out_ready hold the result register and back-pressure the input register.
// Reset is synchronous on rst_n and empties both registers and the parser state.
module websocket_frame_deframer_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wsd_pkg::wsd_in_t  in_beat,
  output logic              out_valid,
  input  logic              out_ready,
  output wsd_pkg::wsd_out_t out_beat
);
  import wsd_pkg::*;

  logic     in_v_r;
  wsd_in_t  in_beat_r;
  logic     fire;
  logic     emit;
  logic     free;
  wsd_out_t res;

  // Move the held byte on when its result (if any) has room
  assign fire     = in_v_r && (!emit || free);
  assign in_ready = !in_v_r || fire;

  // Input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_beat_r <= in_beat;
    end
  end

  wsd_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .beat  (in_beat_r),
    .emit  (emit),
    .res   (res)
  );

  wsd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && emit),
    .load_beat (res),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule

// ===== hw/rtl/wsd_parser.sv =====
// Header parser and payload unmasking state machine, one byte per fire.
module wsd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  wsd_pkg::wsd_in_t  beat,
  output logic              emit,
  output wsd_pkg::wsd_out_t res
);
  import wsd_pkg::*;

  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        mask_r, mask_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] key_r, key_nxt;
  logic [15:0] count_r, count_nxt;
  logic        drop_r, drop_nxt;

  logic [7:0]  b;
  logic        last;
  logic [6:0]  len7;
  logic [3:0]  done_st;
  logic [7:0]  key_byte;
  logic [15:0] count_inc;

  assign b         = beat.byte_value;
  assign last      = beat.last_byte;
  assign len7      = b[6:0];
  assign count_inc = count_r + 16'd1;

  // Pick the completion status from the held opcode
  always_comb begin
    if (opcode_r == OPC_CLOSE) begin
      done_st = ST_CLOSE;
    end else if (opcode_r != OPC_TEXT) begin
      done_st = ST_NONTEXT;
    end else begin
      done_st = ST_TEXT;
    end
  end

  // Select the mask key byte for this payload position
  always_comb begin
    case (count_r[1:0])
      2'd0:    key_byte = key_r[7:0];
      2'd1:    key_byte = key_r[15:8];
      2'd2:    key_byte = key_r[23:16];
      default: key_byte = key_r[31:24];
    endcase
  end

  // Next state and result for the current byte
  always_comb begin
    phase_nxt         = phase_r;
    opcode_nxt        = opcode_r;
    mask_nxt          = mask_r;
    len_nxt           = len_r;
    key_nxt           = key_r;
    count_nxt         = count_r;
    drop_nxt          = drop_r;
    emit              = 1'b0;
    res.payload_byte  = 8'd0;
    res.payload_valid = 1'b0;
    res.frame_opcode  = opcode_r;
    res.status        = ST_RUN;
    res.frame_end     = 1'b0;

    if (drop_r) begin
      // Drop trailing bytes until the chunk ends
      if (last) begin
        drop_nxt  = 1'b0;
        phase_nxt = PH_HDR0;
      end
    end else begin
      case (phase_r)
        PH_HDR1: begin
          mask_nxt = b[7];
          if (len7 == LEN_EXT64) begin
            emit          = 1'b1;
            res.status    = ST_LEN64;
            res.frame_end = 1'b1;
            phase_nxt     = PH_HDR0;
            drop_nxt      = !last;
          end else if (len7 == LEN_EXT16) begin
            len_nxt = 16'd0;
            if (last) begin
              emit          = 1'b1;
              res.status    = ST_EXTMISS;
              res.frame_end = 1'b1;
              phase_nxt     = PH_HDR0;
            end else begin
              phase_nxt = PH_EXT0;
            end
          end else begin
            len_nxt = {9'd0, len7};
            if (!b[7]) begin
              emit          = 1'b1;
              res.status    = ST_UNMASKED;
              res.frame_end = 1'b1;
              phase_nxt     = PH_HDR0;
              drop_nxt      = !last;
            end else if (last) begin
              emit          = 1'b1;
              res.status    = ST_TRUNC;
              res.frame_end = 1'b1;
              phase_nxt     = PH_HDR0;
            end else begin
              key_nxt   = 32'd0;
              phase_nxt = PH_KEY0;
            end
          end
        end
        PH_EXT0: begin
          len_nxt = {b, 8'd0};
          if (last) begin
            emit          = 1'b1;
            res.status    = ST_EXTMISS;
            res.frame_end = 1'b1;
            phase_nxt     = PH_HDR0;
          end else begin
            phase_nxt = PH_EXT1;
          end
        end
        PH_EXT1: begin
          len_nxt = {len_r[15:8], b};
          if (!mask_r) begin
            emit          = 1'b1;
            res.status    = ST_UNMASKED;
            res.frame_end = 1'b1;
            phase_nxt     = PH_HDR0;
            drop_nxt      = !last;
          end else if (last) begin
            emit          = 1'b1;
            res.status    = ST_TRUNC;
            res.frame_end = 1'b1;
            phase_nxt     = PH_HDR0;
          end else begin
            key_nxt   = 32'd0;
            phase_nxt = PH_KEY0;
          end
        end
        PH_KEY0, PH_KEY1, PH_KEY2, PH_KEY3: begin
          // Key byte index is the low two bits of the phase
          case (phase_r[1:0])
            2'd0:    key_nxt[7:0]   = b;
            2'd1:    key_nxt[15:8]  = b;
            2'd2:    key_nxt[23:16] = b;
            default: key_nxt[31:24] = b;
          endcase
          if (phase_r == PH_KEY3 && len_r == 16'd0) begin
            emit          = 1'b1;
            res.status    = done_st;
            res.frame_end = 1'b1;
            phase_nxt     = PH_HDR0;
            drop_nxt      = !last;
          end else if (last) begin
            emit          = 1'b1;
            res.status    = ST_TRUNC;
            res.frame_end = 1'b1;
            phase_nxt     = PH_HDR0;
          end else if (phase_r == PH_KEY3) begin
            count_nxt = 16'd0;
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = phase_r + 4'd1;
          end
        end
        PH_DATA: begin
          // Unmask and emit the payload byte
          emit              = 1'b1;
          res.payload_byte  = b ^ key_byte;
          res.payload_valid = 1'b1;
          count_nxt         = count_inc;
          if (count_inc == len_r) begin
            res.status    = done_st;
            res.frame_end = 1'b1;
            phase_nxt     = PH_HDR0;
            drop_nxt      = !last;
          end else if (last) begin
            res.status    = ST_TRUNC;
            res.frame_end = 1'b1;
            phase_nxt     = PH_HDR0;
          end
        end
        default: begin
          // First header byte; unused phase codes land here too
          opcode_nxt       = b[3:0];
          res.frame_opcode = b[3:0];
          mask_nxt         = 1'b0;
          len_nxt          = 16'd0;
          count_nxt        = 16'd0;
          key_nxt          = 32'd0;
          if (last) begin
            emit          = 1'b1;
            res.status    = ST_SHORT;
            res.frame_end = 1'b1;
            phase_nxt     = PH_HDR0;
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
      endcase
    end
  end

  // Advance parser state on each fired byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= 4'd0;
      mask_r   <= 1'b0;
      len_r    <= 16'd0;
      key_r    <= 32'd0;
      count_r  <= 16'd0;
      drop_r   <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
      count_r  <= count_nxt;
      drop_r   <= drop_nxt;
    end
  end

  a_mid_frame_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit && !res.frame_end |-> res.status == ST_RUN && res.payload_valid)
    else $error("mid-frame result without payload or with final status");

  a_final_status_ends: assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit && res.status != ST_RUN |-> res.frame_end)
    else $error("final status without frame end");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    fire && beat.last_byte |=> phase_r == PH_HDR0 && !drop_r)
    else $error("chunk end did not return parser to first header byte");

  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && drop_r |-> !emit)
    else $error("result emitted while dropping trailing bytes");

endmodule

// ===== hw/rtl/wsd_out_reg.sv =====
// Result register between the parser and the output channel.
module wsd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  wsd_pkg::wsd_out_t load_beat,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output wsd_pkg::wsd_out_t out_beat
);
  import wsd_pkg::*;

  logic     valid_r;
  wsd_out_t beat_r;

  // Register can take a beat when empty or being drained this cycle
  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  // Hold valid until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= load_beat;
    end
  end

endmodule
